>>> src/rmab_pkg.sv
// Package: shared types, constants and arithmetic helpers of the tint and blend kernel.
`default_nettype none
package rmab_pkg;

    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned FIFO_DEPTH = 4;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

    localparam logic [CFG_IDX_W-1:0] CFG_TINT_RED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TINT_GREEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TINT_BLUE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TINT_ALPHA   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_ENABLE = 3'd4;

    typedef struct packed {
        logic [CHAN_W-1:0] src_red;
        logic [CHAN_W-1:0] src_green;
        logic [CHAN_W-1:0] src_blue;
        logic [CHAN_W-1:0] src_opacity;
        logic [CHAN_W-1:0] dst_red;
        logic [CHAN_W-1:0] dst_green;
        logic [CHAN_W-1:0] dst_blue;
        logic [CHAN_W-1:0] dst_alpha;
    } t_pix_in;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_alpha;
    } t_pix_out;

    typedef struct packed {
        logic [CHAN_W-1:0] tint_red;
        logic [CHAN_W-1:0] tint_green;
        logic [CHAN_W-1:0] tint_blue;
        logic [CHAN_W-1:0] tint_alpha;
        logic              blend_enable;
    } t_cfg;

    typedef struct packed {
        logic              blend;
        logic [CHAN_W-1:0] tnt_red;
        logic [CHAN_W-1:0] tnt_green;
        logic [CHAN_W-1:0] tnt_blue;
        logic [CHAN_W-1:0] tnt_alpha;
        logic [CHAN_W-1:0] dst_red;
        logic [CHAN_W-1:0] dst_green;
        logic [CHAN_W-1:0] dst_blue;
        logic [CHAN_W-1:0] dst_alpha;
    } t_tinted;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    function automatic logic [CHAN_W-1:0] scale8(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
        logic [2*CHAN_W-1:0] p;
        p = a * b;
        return p[2*CHAN_W-1:CHAN_W];
    endfunction

endpackage
`default_nettype wire

>>> src/rmab_front.sv
// Front: accept requests, drop transparent sources in blend mode, apply the tint.
`default_nettype none
module rmab_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire rmab_pkg::t_cfg   i_cfg,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire rmab_pkg::t_pix_in i_in_data,
    input  wire rmab_pkg::t_q_status i_q_status,
    output logic                  o_push,
    output rmab_pkg::t_tinted     o_push_data
);

    logic              r_valid;
    logic              n_valid;
    rmab_pkg::t_tinted r_data;
    logic              accept;
    logic              keep;

    assign o_in_stall  = r_valid && i_q_status.full;
    assign o_push      = r_valid && !i_q_status.full;
    assign o_push_data = r_data;
    assign accept      = i_in_valid && !o_in_stall;
    assign keep        = accept && !(i_cfg.blend_enable && (i_in_data.src_opacity == '0));
    assign n_valid     = keep || (r_valid && !o_push);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (keep) begin
            r_data.blend     <= i_cfg.blend_enable;
            r_data.tnt_red   <= rmab_pkg::scale8(i_cfg.tint_red, i_in_data.src_red);
            r_data.tnt_green <= rmab_pkg::scale8(i_cfg.tint_green, i_in_data.src_green);
            r_data.tnt_blue  <= rmab_pkg::scale8(i_cfg.tint_blue, i_in_data.src_blue);
            r_data.tnt_alpha <= rmab_pkg::scale8(i_cfg.tint_alpha, i_in_data.src_opacity);
            r_data.dst_red   <= i_in_data.dst_red;
            r_data.dst_green <= i_in_data.dst_green;
            r_data.dst_blue  <= i_in_data.dst_blue;
            r_data.dst_alpha <= i_in_data.dst_alpha;
        end
    end

endmodule
`default_nettype wire

>>> src/rmab_fifo.sv
// Queue: short first-in first-out buffer of tinted requests between front and back.
`default_nettype none
module rmab_fifo #(
    parameter int unsigned DEPTH = rmab_pkg::FIFO_DEPTH
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire rmab_pkg::t_q_ctrl   i_ctrl,
    input  wire rmab_pkg::t_tinted   i_data,
    output rmab_pkg::t_q_status      o_status,
    output rmab_pkg::t_tinted        o_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    rmab_pkg::t_tinted r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr;
    logic [AW-1:0]     n_wr_ptr;
    logic [AW-1:0]     r_rd_ptr;
    logic [AW-1:0]     n_rd_ptr;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              do_push;
    logic              do_pop;

    assign o_status.full  = (r_count == FULL);
    assign o_status.empty = (r_count == '0);
    assign o_data         = r_mem[r_rd_ptr];
    assign do_push        = i_ctrl.push && !o_status.full;
    assign do_pop         = i_ctrl.pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_ctrl.push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.empty |-> !i_ctrl.pop)
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("queue count out of range");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count lost a push");

endmodule
`default_nettype wire

>>> src/rmab_back.sv
// Back: in blend mode blend tinted requests over the destination, else pass them through; hold the result for the sink.
`default_nettype none
module rmab_back (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire rmab_pkg::t_q_status i_q_status,
    input  wire rmab_pkg::t_tinted   i_q_data,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output rmab_pkg::t_pix_out       o_out_data
);

    logic                r_valid;
    logic                n_valid;
    rmab_pkg::t_pix_out  r_data;
    rmab_pkg::t_pix_out  n_data;
    logic [rmab_pkg::CHAN_W-1:0] inv_a;
    logic [rmab_pkg::CHAN_W:0]   sum_a;
    logic [rmab_pkg::CHAN_W:0]   mix_r;
    logic [rmab_pkg::CHAN_W:0]   mix_g;
    logic [rmab_pkg::CHAN_W:0]   mix_b;

    assign o_pop       = !i_q_status.empty && (!r_valid || !i_out_stall);
    assign n_valid     = o_pop || (r_valid && i_out_stall);
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    assign inv_a = rmab_pkg::CHAN_MAX - i_q_data.tnt_alpha;
    assign sum_a = {1'b0, i_q_data.dst_alpha} + {1'b0, i_q_data.tnt_alpha};
    assign mix_r = {1'b0, rmab_pkg::scale8(i_q_data.dst_red, inv_a)}
                 + {1'b0, rmab_pkg::scale8(i_q_data.tnt_red, i_q_data.tnt_alpha)};
    assign mix_g = {1'b0, rmab_pkg::scale8(i_q_data.dst_green, inv_a)}
                 + {1'b0, rmab_pkg::scale8(i_q_data.tnt_green, i_q_data.tnt_alpha)};
    assign mix_b = {1'b0, rmab_pkg::scale8(i_q_data.dst_blue, inv_a)}
                 + {1'b0, rmab_pkg::scale8(i_q_data.tnt_blue, i_q_data.tnt_alpha)};

    always_comb begin
        n_data.out_red   = i_q_data.tnt_red;
        n_data.out_green = i_q_data.tnt_green;
        n_data.out_blue  = i_q_data.tnt_blue;
        n_data.out_alpha = i_q_data.tnt_alpha;
        if (i_q_data.blend) begin
            if (i_q_data.dst_alpha != '0) begin
                n_data.out_red   = mix_r[rmab_pkg::CHAN_W-1:0];
                n_data.out_green = mix_g[rmab_pkg::CHAN_W-1:0];
                n_data.out_blue  = mix_b[rmab_pkg::CHAN_W-1:0];
            end
            n_data.out_alpha = sum_a[rmab_pkg::CHAN_W] ? rmab_pkg::CHAN_MAX
                                                       : sum_a[rmab_pkg::CHAN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
        end
    end

endmodule
`default_nettype wire

>>> src/rgba_modulate_alpha_blend.sv
// Top level: configuration registers, front, queue and back of the tint and blend kernel.
`default_nettype none
// Per-pixel tint and alpha blend. Each request carries a source and a destination
// RGBA8888 pixel; the source is scaled by the tint registers and, with blend_enable
// set, mixed over the destination by the tinted alpha. In blend mode a source with
// zero alpha is consumed and produces no result. Throughput is one pixel per clock
// while nothing stalls: the tint multipliers in the front and the blend multipliers
// in the back each take one request per cycle. A result passes through the front
// register, the queue and the output register; the queue of FIFO_DEPTH entries
// lets the two halves stall independently.
// Write configuration only while no requests are in flight.
module rgba_modulate_alpha_blend #(
    parameter int unsigned FIFO_DEPTH = rmab_pkg::FIFO_DEPTH
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire [rmab_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [rmab_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire rmab_pkg::t_pix_in            i_in_data,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output rmab_pkg::t_pix_out                o_out_data
);

    rmab_pkg::t_cfg      r_cfg;
    rmab_pkg::t_cfg      n_cfg;
    rmab_pkg::t_q_status q_status;
    rmab_pkg::t_q_ctrl   q_ctrl;
    logic                q_push;
    logic                q_pop;
    rmab_pkg::t_tinted   push_data;
    rmab_pkg::t_tinted   head_data;

    assign q_ctrl = '{push: q_push, pop: q_pop};

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                rmab_pkg::CFG_TINT_RED:     n_cfg.tint_red     = i_cfg_data;
                rmab_pkg::CFG_TINT_GREEN:   n_cfg.tint_green   = i_cfg_data;
                rmab_pkg::CFG_TINT_BLUE:    n_cfg.tint_blue    = i_cfg_data;
                rmab_pkg::CFG_TINT_ALPHA:   n_cfg.tint_alpha   = i_cfg_data;
                rmab_pkg::CFG_BLEND_ENABLE: n_cfg.blend_enable = i_cfg_data[0];
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tint_red     <= rmab_pkg::CHAN_MAX;
            r_cfg.tint_green   <= rmab_pkg::CHAN_MAX;
            r_cfg.tint_blue    <= rmab_pkg::CHAN_MAX;
            r_cfg.tint_alpha   <= rmab_pkg::CHAN_MAX;
            r_cfg.blend_enable <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    rmab_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_q_status  (q_status),
        .o_push      (q_push),
        .o_push_data (push_data)
    );

    rmab_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (q_ctrl),
        .i_data   (push_data),
        .o_status (q_status),
        .o_data   (head_data)
    );

    rmab_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_q_data    (head_data),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
